>>> rtl/core/pu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pu_pkg
// Shared constants, types and the factorial table for the permutation unranker.
// ----------------------------------------------------------------------------
package pu_pkg;

	localparam int MAX_ELEMENTS = 8;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = 4;
	localparam int RANK_W       = 16;
	localparam int UNIT_W       = RANK_W + 1;
	localparam int VAL_W        = 3;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_ELEMENTS);

	// result of the shared subtract/compare unit
	typedef struct packed {
		logic              ge;
		logic [UNIT_W-1:0] diff;
	} unit_res_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_LOAD  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// k! for k = 0..8; larger arguments saturate past the 16-bit rank range
	function automatic logic [UNIT_W-1:0] fact(input logic [CNT_W-1:0] k);
		logic [UNIT_W-1:0] r;
		case (k)
			4'd0:    r = UNIT_W'(1);
			4'd1:    r = UNIT_W'(1);
			4'd2:    r = UNIT_W'(2);
			4'd3:    r = UNIT_W'(6);
			4'd4:    r = UNIT_W'(24);
			4'd5:    r = UNIT_W'(120);
			4'd6:    r = UNIT_W'(720);
			4'd7:    r = UNIT_W'(5040);
			4'd8:    r = UNIT_W'(40320);
			default: r = {1'b1, {(UNIT_W-1){1'b0}}};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/pu_sub_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pu_sub_unit
// Shared subtract-and-compare unit: difference a - b and the a >= b flag.
// ----------------------------------------------------------------------------
module pu_sub_unit (
	input  wire logic [pu_pkg::UNIT_W-1:0] op_a,
	input  wire logic [pu_pkg::UNIT_W-1:0] op_b,
	output pu_pkg::unit_res_t              res
);
	import pu_pkg::*;

	logic [UNIT_W:0] wide;

	always_comb begin
		wide     = {1'b0, op_a} - {1'b0, op_b};
		res.ge   = ~wide[UNIT_W];
		res.diff = wide[UNIT_W-1:0];
	end

endmodule
`default_nettype wire

>>> rtl/core/permutation_unrank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// permutation_unrank
// Turns a lexicographic rank into the permutation of n elements, one element
// per result in position order, with a single flagged result for a bad rank.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       in         in_valid / in_stall    rank
//  out      out        out_valid / out_stall  position, element, last, out_of_range
//  cfg      in         cfg_valid / cfg_ready  elements_in_use
//
//  A rank runs its arithmetic on the one shared subtractor: a range check,
//  three restoring division steps per factorial digit, one compare per pair
//  of the increment pass. A bad rank goes from the range check straight to
//  its flagged result. in_stall is high while a rank is in work.
//  The output register holds a result under out_stall; the next rank is taken
//  while the final result still waits. Reset sets n to 8.
// ----------------------------------------------------------------------------
module permutation_unrank (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [pu_pkg::RANK_W-1:0]  rank,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [pu_pkg::VAL_W-1:0]        position,
	output logic [pu_pkg::VAL_W-1:0]        element,
	output logic                            last,
	output logic                            out_of_range,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pu_pkg::CNT_W-1:0]   elements_in_use
);
	import pu_pkg::*;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [RANK_W-1:0] rest_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  idx_q;
	logic [1:0]        bit_q;
	logic [1:0]        dig_q;
	logic [VAL_W-1:0]  cur_q;
	logic              err_q;
	logic [VAL_W-1:0]  store_q [MAX_ELEMENTS];

	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  n_last;
	logic [CNT_W-1:0]  fact_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic [UNIT_W-1:0] op_a;
	logic [UNIT_W-1:0] op_b;
	unit_res_t         ures;
	logic              out_free;
	logic [VAL_W-1:0]  cur_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = ~out_valid | ~out_stall;

	always_comb begin
		if (count_q == '0)
			n_eff = CNT_W'(1);
		else if (count_q > CNT_W'(MAX_ELEMENTS))
			n_eff = CNT_W'(MAX_ELEMENTS);
		else
			n_eff = count_q;
	end

	assign n_last   = n_q - CNT_W'(1);
	assign fact_idx = n_last - {{(CNT_W-IDX_W){1'b0}}, k_q};

	always_comb begin
		case (state_q)
			ST_LOAD: rd_addr = k_q;
			ST_CMP:  rd_addr = j_q;
			default: rd_addr = idx_q;
		endcase
	end
	assign rd_data = store_q[rd_addr];

	// operand select for the shared unit
	always_comb begin
		case (state_q)
			ST_CHECK: begin
				op_a = {1'b0, rest_q};
				op_b = fact(n_q);
			end
			ST_DIV: begin
				op_a = {1'b0, rest_q};
				op_b = fact(fact_idx) << bit_q;
			end
			ST_CMP: begin
				op_a = UNIT_W'(cur_q);
				op_b = UNIT_W'(rd_data);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	pu_sub_unit u_sub (
		.op_a (op_a),
		.op_b (op_b),
		.res  (ures)
	);

	// increment when the earlier digit is less than or equal to this one
	assign cur_next = ures.ge ? cur_q + VAL_W'(1) : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= elements_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid    <= 1'b0;
			rest_q       <= '0;
			n_q          <= CNT_W'(1);
			k_q          <= '0;
			j_q          <= '0;
			idx_q        <= '0;
			bit_q        <= '0;
			dig_q        <= '0;
			cur_q        <= '0;
			err_q        <= 1'b0;
			position     <= '0;
			element      <= '0;
			last         <= 1'b0;
			out_of_range <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rest_q  <= rank;
						n_q     <= n_eff;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					k_q   <= '0;
					bit_q <= 2'd2;
					dig_q <= '0;
					idx_q <= '0;
					err_q <= ures.ge;
					state_q <= ures.ge ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (ures.ge)
						rest_q <= ures.diff[RANK_W-1:0];
					if (bit_q == 2'd0) begin
						store_q[k_q] <= {dig_q, ures.ge};
						bit_q <= 2'd2;
						dig_q <= '0;
						if ({1'b0, k_q} == n_last) begin
							state_q <= (n_last == '0) ? ST_EMIT : ST_LOAD;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end else begin
						dig_q <= {dig_q[0], ures.ge};
						bit_q <= bit_q - 2'd1;
					end
				end
				ST_LOAD: begin
					cur_q   <= rd_data;
					j_q     <= k_q - IDX_W'(1);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cur_q <= cur_next;
					if (j_q == '0) begin
						store_q[k_q] <= cur_next;
						if (k_q == IDX_W'(1)) begin
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q - IDX_W'(1);
							state_q <= ST_LOAD;
						end
					end else begin
						j_q <= j_q - IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						position     <= err_q ? '0 : VAL_W'(idx_q);
						element      <= err_q ? '0 : rd_data;
						out_of_range <= err_q;
						if (err_q || ({1'b0, idx_q} == n_last)) begin
							last    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							last  <= 1'b0;
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_err_single : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> last && element == '0 && position == '0)
		else $error("range error result is not a lone final result");

	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken without going busy");

	a_position_bound : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |-> {1'b0, position} <= n_last)
		else $error("position beyond element count");

	a_last_marks_end : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> state_q == ST_EMIT)
		else $error("non-final result left the sequencer idle");
`endif

endmodule
`default_nettype wire

>>> bench/permutation_unrank_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_test
// Sends ranks to the unranker under the element counts 0 to 9 and 15 and
// checks each emitted element, its position and the last and out_of_range
// flags against a factoradic unranking predictor. Both sides idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [pu_pkg::VAL_W-1:0] position;
	logic [pu_pkg::VAL_W-1:0] element;
	logic                     last;
	logic                     out_of_range;
} perm_slot_t;

class unrank_board;
	logic [pu_pkg::CNT_W-1:0]  count_reg;
	logic [pu_pkg::VAL_W-1:0]  digits[pu_pkg::MAX_ELEMENTS];
	logic [pu_pkg::RANK_W-1:0] leftover;
	perm_slot_t                slots_q[$];
	int                        errors;

	function new();
		count_reg = pu_pkg::COUNT_RESET;
		leftover  = '0;
		errors    = 0;
		foreach (digits[k]) digits[k] = '0;
	endfunction

	function void set_count(logic [pu_pkg::CNT_W-1:0] v);
		count_reg = v;
	endfunction

	function int used_count();
		int n;
		n = count_reg;
		if (n < 1)
			n = 1;
		if (n > pu_pkg::MAX_ELEMENTS)
			n = pu_pkg::MAX_ELEMENTS;
		return n;
	endfunction

	// n! for the current count
	function int rank_limit();
		int f;
		f = 1;
		for (int k = 2; k <= used_count(); k++)
			f = f * k;
		return f;
	endfunction

	function void note_rank(logic [pu_pkg::RANK_W-1:0] r);
		int         n;
		int         rest;
		int         f[pu_pkg::MAX_ELEMENTS];
		perm_slot_t s;
		n = used_count();
		f[0] = 1;
		for (int k = 1; k < n; k++)
			f[k] = f[k-1] * k;
		if (int'(r) >= f[n-1] * n) begin
			leftover       = r;
			s.position     = '0;
			s.element      = '0;
			s.last         = 1'b1;
			s.out_of_range = 1'b1;
			slots_q.push_back(s);
			return;
		end
		rest = r;
		for (int k = 0; k < n; k++) begin
			digits[k] = pu_pkg::VAL_W'(rest / f[n-1-k]);
			rest = rest % f[n-1-k];
		end
		leftover = pu_pkg::RANK_W'(rest);
		// bump each digit past every earlier element at or below it
		for (int k = n - 1; k > 0; k--)
			for (int j = k - 1; j >= 0; j--)
				if (digits[j] <= digits[k])
					digits[k] = digits[k] + 1'b1;
		for (int k = 0; k < n; k++) begin
			s.position     = pu_pkg::VAL_W'(k);
			s.element      = digits[k];
			s.last         = (k == n - 1);
			s.out_of_range = 1'b0;
			slots_q.push_back(s);
		end
	endfunction

	function void check_result(perm_slot_t got);
		perm_slot_t want;
		if (slots_q.size() == 0) begin
			$error("result at position %0d arrived with no request pending", got.position);
			errors++;
			return;
		end
		want = slots_q.pop_front();
		if (got.position !== want.position) begin
			$error("position: expected %0d, got %0d", want.position, got.position);
			errors++;
		end
		if (got.element !== want.element) begin
			$error("element: expected %0d, got %0d", want.element, got.element);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
		if (got.out_of_range !== want.out_of_range) begin
			$error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
			errors++;
		end
	endfunction

	function int waiting();
		return slots_q.size();
	endfunction
endclass

module permutation_unrank_test;

	localparam int          SETTLE_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          PHASE_ITEMS   = 36;

	logic                        clk             = 1'b0;
	logic                        arst_n          = 1'b0;
	logic                        in_valid        = 1'b0;
	logic                        in_stall;
	logic [pu_pkg::RANK_W-1:0]   rank            = '0;
	logic                        out_valid;
	logic                        out_stall       = 1'b0;
	logic [pu_pkg::VAL_W-1:0]    position;
	logic [pu_pkg::VAL_W-1:0]    element;
	logic                        last;
	logic                        out_of_range;
	logic                        cfg_valid       = 1'b0;
	logic                        cfg_ready;
	logic [pu_pkg::CNT_W-1:0]    elements_in_use = '0;

	unrank_board board = new();
	bit          idling = 1'b0;
	int          stall_run = 0;
	int unsigned cycles = 0;

	permutation_unrank dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rank            (rank),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.position        (position),
		.element         (element),
		.last            (last),
		.out_of_range    (out_of_range),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.elements_in_use (elements_in_use)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("permutation_unrank_test NOT OK");
			$finish;
		end
	end

	// receiver: stall in bursts while idling is on
	always @(posedge clk) begin
		if (stall_run > 1) begin
			stall_run <= stall_run - 1;
		end else if (stall_run == 1) begin
			stall_run <= 0;
			out_stall <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_run <= $urandom_range(1, 9);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{position, element, last, out_of_range});
	end

	task automatic send_rank(input logic [pu_pkg::RANK_W-1:0] r);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rank     <= r;
		do @(posedge clk); while (in_stall);
		board.note_rank(r);
	endtask

	// drop valid and let every pending result drain
	task automatic drain();
		in_valid <= 1'b0;
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [pu_pkg::CNT_W-1:0] v);
		cfg_valid       <= 1'b1;
		elements_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_count(v);
	endtask

	task automatic run_phase(input int items);
		int lim;
		int sel;
		lim = board.rank_limit();
		send_rank('0);
		send_rank(pu_pkg::RANK_W'(lim - 1));
		send_rank(lim <= 65535 ? pu_pkg::RANK_W'(lim) : '1);
		send_rank('1);
		for (int i = 4; i < items; i++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				send_rank(pu_pkg::RANK_W'($urandom_range(0, 65535)));
			else if (sel == 1 && lim <= 65535)
				send_rank(pu_pkg::RANK_W'($urandom_range(lim, 65535)));
			else
				send_rank(pu_pkg::RANK_W'($urandom_range(0, lim - 1)));
		end
	endtask

	initial begin
		logic [pu_pkg::RANK_W-1:0] edge_ranks[$];
		logic [pu_pkg::CNT_W-1:0]  counts[$];
		edge_ranks = '{16'd0, 16'd1, 16'd40319, 16'd40320, 16'hFFFF, 16'h5555,
			16'hAAAA, 16'd5039, 16'd5040, 16'd720, 16'd1234, 16'd40000};
		counts = '{4'd1, 4'd0, 4'd2, 4'd3, 4'd4, 4'd15, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling = 1'b1;
		foreach (edge_ranks[i])
			send_rank(edge_ranks[i]);
		foreach (counts[ph]) begin
			drain();
			write_count(counts[ph]);
			idling = (ph < counts.size() - 1) && (ph % 4 != 2);
			run_phase(PHASE_ITEMS);
		end
		drain();
		if (board.errors == 0)
			$display("permutation_unrank_test OK");
		else
			$display("permutation_unrank_test NOT OK");
		$finish;
	end

endmodule
